FILE: rtl/hio_pkg.sv
// Shared types, register offsets and decode helpers for the handheld I/O register block.
// No dependencies; hio_state, hio_resp and the top level import this package.

package hio_pkg;

   // operation codes
   localparam logic [1:0] OP_READ   = 2'd0;
   localparam logic [1:0] OP_WRITE  = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   // palette kinds for lookups
   localparam logic [2:0] KIND_MONO_BG   = 3'd0;
   localparam logic [2:0] KIND_MONO_OBJ0 = 3'd1;
   localparam logic [2:0] KIND_MONO_OBJ1 = 3'd2;
   localparam logic [2:0] KIND_COLOUR_BG = 3'd3;
   localparam logic [2:0] KIND_COLOUR_SP = 3'd4;

   // register offsets within the I/O window
   localparam logic [6:0] OFF_JOYPAD     = 7'h00;
   localparam logic [6:0] OFF_TIMER_CTRL = 7'h07;
   localparam logic [6:0] OFF_LCD_CTRL   = 7'h40;
   localparam logic [6:0] OFF_LCD_STAT   = 7'h41;
   localparam logic [6:0] OFF_LCD_Y      = 7'h44;
   localparam logic [6:0] OFF_BG_MAP     = 7'h47;
   localparam logic [6:0] OFF_OBJ0_MAP   = 7'h48;
   localparam logic [6:0] OFF_OBJ1_MAP   = 7'h49;
   localparam logic [6:0] OFF_VRAM_BANK  = 7'h4F;
   localparam logic [6:0] OFF_BG_INDEX   = 7'h68;
   localparam logic [6:0] OFF_BG_DATA    = 7'h69;
   localparam logic [6:0] OFF_SP_INDEX   = 7'h6A;
   localparam logic [6:0] OFF_SP_DATA    = 7'h6B;
   localparam logic [6:0] OFF_WRAM_BANK  = 7'h70;

   localparam logic [7:0] MONO_MAP_RESET = 8'hE4;

   typedef struct packed {
      logic [1:0] op;
      logic [6:0] reg_offset;
      logic [7:0] write_data;
      logic [2:0] palette_kind;
      logic [2:0] palette_number;
      logic [1:0] color_index;
      logic [7:0] button_states;
      logic [1:0] lcd_mode;
      logic       coincidence;
      logic [7:0] current_line;
   } hio_req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [4:0]  red;
      logic [4:0]  green;
      logic [4:0]  blue;
      logic        line_reset;
      logic [10:0] timer_period;
      logic        timer_halted;
      logic [2:0]  work_bank;
      logic        video_bank;
      logic [7:0]  lcd_control;
   } hio_rsp_type;

   // decoded side state kept in flops
   typedef struct packed {
      logic        direction_select;
      logic        button_select;
      logic [10:0] timer_period;
      logic        timer_halted;
      logic [2:0]  work_bank;
      logic        video_bank;
      logic [7:0]  mono_bg;
      logic [7:0]  mono_obj0;
      logic [7:0]  mono_obj1;
      logic        bg_auto_step;
      logic        sp_auto_step;
      logic [7:0]  bg_index;
      logic [7:0]  sp_index;
      logic [7:0]  lcd_control;
   } hio_state_type;

   localparam hio_state_type STATE_RESET = '{
      direction_select: 1'b0,
      button_select:    1'b0,
      timer_period:     11'd0,
      timer_halted:     1'b0,
      work_bank:        3'd0,
      video_bank:       1'b0,
      mono_bg:          MONO_MAP_RESET,
      mono_obj0:        MONO_MAP_RESET,
      mono_obj1:        MONO_MAP_RESET,
      bg_auto_step:     1'b0,
      sp_auto_step:     1'b0,
      bg_index:         8'd0,
      sp_index:         8'd0,
      lcd_control:      8'd0
   };

   // colour entries live in two halves: lo = {green[2:0], red}, hi = {blue, green[4:3]}
   typedef struct packed {
      logic       bg_lo_we;
      logic       bg_hi_we;
      logic       sp_lo_we;
      logic       sp_hi_we;
      logic [4:0] slot;
      logic [7:0] lo_data;
      logic [6:0] hi_data;
   } hio_palwr_type;

   typedef struct packed {
      logic [7:0] lo;
      logic       lo_valid;
      logic [6:0] hi;
      logic       hi_valid;
   } hio_palrd_type;

   function automatic logic [10:0] timer_period_decode(input logic [1:0] sel);
      logic [10:0] period;
      case (sel)
         2'd0:    period = 11'd1024;
         2'd1:    period = 11'd16;
         2'd2:    period = 11'd64;
         default: period = 11'd256;
      endcase
      return period;
   endfunction

   // assemble a 15-bit colour {blue, green, red}, substituting the grey reset value
   function automatic logic [14:0] colour_entry(input hio_palrd_type rd,
                                               input logic [1:0] entry);
      logic [7:0] lo;
      logic [6:0] hi;
      lo = rd.lo_valid ? rd.lo : {3'b000, entry, 3'b000};
      hi = rd.hi_valid ? rd.hi : {entry, 3'b000, entry};
      return {hi[6:2], hi[1:0], lo[7:5], lo[4:0]};
   endfunction

endpackage

FILE: rtl/hio_ram.sv
// Single-write, single-read memory with registered read data and per-entry written flags.
// Depends on nothing; the user substitutes the reset value of entries never written.

module hio_ram #(
   parameter int ADDR_W = 5,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   output logic              rd_valid
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  written_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_valid_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // mark entries as written; reset drops every mark at once
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff  <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= written_ff[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

FILE: rtl/hio_state.sv
// Decoded side state (joypad select, timer, banks, mono maps, palette index registers)
// and the colour palette write commands. Depends on hio_pkg.

module hio_state import hio_pkg::*; #(
   parameter int COLOUR_PALETTES = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  hio_req_type   req,
   output hio_state_type state,
   output hio_palwr_type palwr
);

   localparam logic [3:0] PAL_COUNT = 4'(COLOUR_PALETTES);

   hio_state_type state_ff;
   hio_state_type state_in;

   // decode a register write into new side state and palette writes
   always_comb begin
      state_in = state_ff;
      palwr    = '0;
      if (accept && req.op == OP_WRITE) begin
         case (req.reg_offset)
            OFF_JOYPAD: begin
               state_in.direction_select = ~req.write_data[4];
               state_in.button_select    = ~req.write_data[5];
            end
            OFF_TIMER_CTRL: begin
               state_in.timer_period = timer_period_decode(req.write_data[1:0]);
               state_in.timer_halted = ~req.write_data[2];
            end
            OFF_LCD_CTRL:  state_in.lcd_control = req.write_data;
            OFF_BG_MAP:    state_in.mono_bg     = req.write_data;
            OFF_OBJ0_MAP:  state_in.mono_obj0   = req.write_data;
            OFF_OBJ1_MAP:  state_in.mono_obj1   = req.write_data;
            OFF_VRAM_BANK: state_in.video_bank  = req.write_data[0];
            OFF_BG_INDEX: begin
               state_in.bg_index     = req.write_data;
               state_in.bg_auto_step = req.write_data[7];
            end
            OFF_SP_INDEX: begin
               state_in.sp_index     = req.write_data;
               state_in.sp_auto_step = req.write_data[7];
            end
            OFF_BG_DATA: begin
               palwr.slot     = state_ff.bg_index[5:1];
               palwr.lo_data  = req.write_data;
               palwr.hi_data  = req.write_data[6:0];
               if ({1'b0, state_ff.bg_index[5:3]} < PAL_COUNT) begin
                  palwr.bg_lo_we = ~state_ff.bg_index[0];
                  palwr.bg_hi_we = state_ff.bg_index[0];
               end
               if (state_ff.bg_auto_step) begin
                  state_in.bg_index[5:0] = state_ff.bg_index[5:0] + 6'd1;
               end
            end
            OFF_SP_DATA: begin
               palwr.slot     = state_ff.sp_index[5:1];
               palwr.lo_data  = req.write_data;
               palwr.hi_data  = req.write_data[6:0];
               if ({1'b0, state_ff.sp_index[5:3]} < PAL_COUNT) begin
                  palwr.sp_lo_we = ~state_ff.sp_index[0];
                  palwr.sp_hi_we = state_ff.sp_index[0];
               end
               if (state_ff.sp_auto_step) begin
                  state_in.sp_index[5:0] = state_ff.sp_index[5:0] + 6'd1;
               end
            end
            OFF_WRAM_BANK: begin
               state_in.work_bank = (req.write_data[2:0] == 3'd0) ? 3'd1
                                                                  : req.write_data[2:0];
            end
            default: begin
            end
         endcase
      end
   end

   // hold side state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

FILE: rtl/hio_resp.sv
// Result assembly: register read mux, palette lookup and the registered result beat.
// Depends on hio_pkg.

module hio_resp import hio_pkg::*; #(
   parameter int COLOUR_PALETTES = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   input  hio_req_type   item,
   input  hio_state_type state,
   input  logic [7:0]    reg_rd_data,
   input  logic          reg_rd_valid,
   input  hio_palrd_type bg_rd,
   input  hio_palrd_type sp_rd,
   output logic          rsp_strobe,
   output hio_rsp_type   rsp_data
);

   localparam logic [3:0] PAL_COUNT = 4'(COLOUR_PALETTES);

   hio_rsp_type rsp_ff;
   hio_rsp_type rsp_in;
   logic        rsp_strobe_ff;
   logic [7:0]  stored_byte;
   logic [7:0]  read_byte;
   logic [7:0]  mono_map;
   logic [1:0]  shade;
   logic [4:0]  grey;
   logic [14:0] colour;
   logic        pal_ok;

   assign stored_byte = reg_rd_valid ? reg_rd_data : 8'd0;
   assign pal_ok      = {1'b0, item.palette_number} < PAL_COUNT;

   // register read mux
   always_comb begin
      case (item.reg_offset)
         OFF_JOYPAD: begin
            read_byte[3:0] = state.direction_select ? ~item.button_states[3:0]
                                                    : ~item.button_states[7:4];
            read_byte[4]   = ~state.direction_select;
            read_byte[5]   = ~state.button_select;
            read_byte[7:6] = 2'b00;
         end
         OFF_LCD_STAT:  read_byte = {stored_byte[7:3], item.coincidence, item.lcd_mode};
         OFF_LCD_Y:     read_byte = item.current_line;
         OFF_LCD_CTRL:  read_byte = state.lcd_control;
         OFF_VRAM_BANK: read_byte = {7'd0, state.video_bank};
         OFF_BG_INDEX:  read_byte = state.bg_index;
         OFF_SP_INDEX:  read_byte = state.sp_index;
         OFF_WRAM_BANK: read_byte = {5'd0, state.work_bank};
         default:       read_byte = stored_byte;
      endcase
   end

   // palette lookup
   always_comb begin
      case (item.palette_kind)
         KIND_MONO_OBJ0: mono_map = state.mono_obj0;
         KIND_MONO_OBJ1: mono_map = state.mono_obj1;
         default:        mono_map = state.mono_bg;
      endcase
      shade = mono_map[{item.color_index, 1'b0} +: 2];
      grey  = {shade, 3'b000};
      case (item.palette_kind)
         KIND_MONO_BG, KIND_MONO_OBJ0, KIND_MONO_OBJ1: colour = {grey, grey, grey};
         KIND_COLOUR_BG: colour = pal_ok ? colour_entry(bg_rd, item.color_index) : 15'd0;
         KIND_COLOUR_SP: colour = pal_ok ? colour_entry(sp_rd, item.color_index) : 15'd0;
         default:        colour = 15'd0;
      endcase
   end

   // build the result beat
   always_comb begin
      rsp_in              = '0;
      rsp_in.read_data    = (item.op == OP_READ) ? read_byte : 8'd0;
      if (item.op == OP_LOOKUP) begin
         rsp_in.red   = colour[4:0];
         rsp_in.green = colour[9:5];
         rsp_in.blue  = colour[14:10];
      end
      rsp_in.line_reset   = (item.op == OP_WRITE) && (item.reg_offset == OFF_LCD_Y);
      rsp_in.timer_period = state.timer_period;
      rsp_in.timer_halted = state.timer_halted;
      rsp_in.work_bank    = state.work_bank;
      rsp_in.video_bank   = state.video_bank;
      rsp_in.lcd_control  = state.lcd_control;
   end

   // register the result
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= item_valid;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

FILE: rtl/handheld_io_register_block.sv
// Top level of the handheld I/O register block: input register, register-byte memory,
// colour palette memories, side state and result stage. Depends on hio_pkg, hio_ram,
// hio_state and hio_resp.
//
//   channel   ports                     beat marked by
//   --------  ------------------------  -----------------------------
//   request   start, busy, req_data     start high while busy low
//   result    rsp_strobe, rsp_data      rsp_strobe high for one cycle
//
// One beat per cycle while busy is low; requests pass the input and the result registers.
// State, register bytes and palette entries change at the edge that takes the request,
// so the next request in the following cycle already sees them.
// busy is high only during reset; the memories need no clearing pass because each
// entry carries a written flag that reset drops.
// The result strobe cannot be held off.

module handheld_io_register_block import hio_pkg::*; #(
   parameter int REG_WINDOW      = 128,
   parameter int COLOUR_PALETTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  hio_req_type req_data,
   output logic        rsp_strobe,
   output hio_rsp_type rsp_data
);

   localparam int REG_AW = $clog2(REG_WINDOW);
   localparam int PAL_AW = $clog2(COLOUR_PALETTES * 4);

   logic          accept;
   hio_req_type   item_ff;
   logic          item_valid_ff;
   hio_state_type state;
   hio_palwr_type palwr;
   logic [7:0]    reg_rd_data;
   logic          reg_rd_valid;
   hio_palrd_type bg_rd;
   hio_palrd_type sp_rd;
   logic [4:0]    lookup_slot;

   assign busy        = reset;
   assign accept      = start & ~busy;
   assign lookup_slot = {req_data.palette_number, req_data.color_index};

   // capture the request beat
   always_ff @(posedge clock) begin
      item_ff <= req_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= accept;
      end
   end

   hio_state #(
      .COLOUR_PALETTES(COLOUR_PALETTES)
   ) u_state (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .state  (state),
      .palwr  (palwr)
   );

   // raw register bytes of the I/O window
   hio_ram #(
      .ADDR_W(REG_AW),
      .DATA_W(8)
   ) u_reg_ram (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept && req_data.op == OP_WRITE),
      .wr_addr  (REG_AW'(req_data.reg_offset)),
      .wr_data  (req_data.write_data),
      .rd_addr  (REG_AW'(req_data.reg_offset)),
      .rd_data  (reg_rd_data),
      .rd_valid (reg_rd_valid)
   );

   // background colour palettes, low and high halves
   hio_ram #(
      .ADDR_W(PAL_AW),
      .DATA_W(8)
   ) u_bg_lo_ram (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (palwr.bg_lo_we),
      .wr_addr  (palwr.slot[PAL_AW-1:0]),
      .wr_data  (palwr.lo_data),
      .rd_addr  (lookup_slot[PAL_AW-1:0]),
      .rd_data  (bg_rd.lo),
      .rd_valid (bg_rd.lo_valid)
   );

   hio_ram #(
      .ADDR_W(PAL_AW),
      .DATA_W(7)
   ) u_bg_hi_ram (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (palwr.bg_hi_we),
      .wr_addr  (palwr.slot[PAL_AW-1:0]),
      .wr_data  (palwr.hi_data),
      .rd_addr  (lookup_slot[PAL_AW-1:0]),
      .rd_data  (bg_rd.hi),
      .rd_valid (bg_rd.hi_valid)
   );

   // sprite colour palettes, low and high halves
   hio_ram #(
      .ADDR_W(PAL_AW),
      .DATA_W(8)
   ) u_sp_lo_ram (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (palwr.sp_lo_we),
      .wr_addr  (palwr.slot[PAL_AW-1:0]),
      .wr_data  (palwr.lo_data),
      .rd_addr  (lookup_slot[PAL_AW-1:0]),
      .rd_data  (sp_rd.lo),
      .rd_valid (sp_rd.lo_valid)
   );

   hio_ram #(
      .ADDR_W(PAL_AW),
      .DATA_W(7)
   ) u_sp_hi_ram (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (palwr.sp_hi_we),
      .wr_addr  (palwr.slot[PAL_AW-1:0]),
      .wr_data  (palwr.hi_data),
      .rd_addr  (lookup_slot[PAL_AW-1:0]),
      .rd_data  (sp_rd.hi),
      .rd_valid (sp_rd.hi_valid)
   );

   hio_resp #(
      .COLOUR_PALETTES(COLOUR_PALETTES)
   ) u_resp (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (item_valid_ff),
      .item         (item_ff),
      .state        (state),
      .reg_rd_data  (reg_rd_data),
      .reg_rd_valid (reg_rd_valid),
      .bg_rd        (bg_rd),
      .sp_rd        (sp_rd),
      .rsp_strobe   (rsp_strobe),
      .rsp_data     (rsp_data)
   );

endmodule
